/* src/qsort_pkg.sv */
`default_nettype none

package qsort_pkg;

    // default buffer depth and element width
    localparam int DEFAULT_DEPTH       = 64;
    localparam int DEFAULT_VALUE_WIDTH = 32;

endpackage

`default_nettype wire

/* src/qsort_ram.sv */
`default_nettype none

module qsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/quicksort_buffer_sorter.sv */
`default_nettype none

// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_ready      i_value, i_last
// output    out        o_out_valid / i_out_ready    o_sorted_value, o_final_res, o_overflow
//
// Loading takes one cycle per transaction; items beyond DEPTH are dropped.
// Partitioning a range is paced by the single read port of the element memory:
// each pop passes S_POP and S_POPW, each swap S_SWP1 and S_SWP2.
// Pivot is a range's last entry, so sorted or equal values sort far slower than random sets.
// A result waits in S_OHOLD until taken, then the next is read; o_in_ready is low from the last transaction
// until the final result is taken. Reset clears control state, not the memories.
module quicksort_buffer_sorter #(
    parameter int DEPTH       = qsort_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = qsort_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_last,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [VALUE_WIDTH-1:0] o_sorted_value,
    output logic                        o_final_res,
    output logic                        o_overflow
);

    import qsort_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 2 * IW;

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_POPW, S_PIV, S_CMP, S_SWP1, S_SWP2,
        S_FIN, S_FIN1, S_FIN2, S_PUSHR, S_ORD, S_OWAIT, S_OHOLD
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sp, n_sp;
    logic          r_dropped, n_dropped;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_b, n_b;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    logic [VALUE_WIDTH-1:0] r_pivot, n_pivot;
    logic [VALUE_WIDTH-1:0] r_aj, n_aj;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_final, n_out_final;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;

    // memory ports
    logic                   mem_we, mem_re;
    logic [IW-1:0]          mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
    logic                   stk_we, stk_re;
    logic [IW-1:0]          stk_waddr, stk_raddr;
    logic [SW-1:0]          stk_wdata, stk_rdata;

    // helpers
    logic          in_fire;
    logic [CW-1:0] total;
    logic [IW-1:0] j_next;
    logic          le_pivot;

    qsort_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    qsort_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_en   (stk_re),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

    assign o_in_ready     = (r_state == S_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;
    assign o_overflow     = r_dropped;

    assign in_fire  = i_in_valid && o_in_ready;
    assign total    = (r_count < CW'(DEPTH)) ? r_count + CW'(1) : r_count;
    assign j_next   = r_j + IW'(1);
    assign le_pivot = $signed(mem_rdata) <= $signed(r_pivot);

    // sequencer: load, partition, emit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_dropped   = r_dropped;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_b         = r_b;
        n_j         = r_j;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_aj        = r_aj;
        n_out_valid = r_out_valid;
        n_out_final = r_out_final;
        n_out_value = r_out_value;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_raddr   = '0;

        unique case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    // store or drop the element
                    if (r_count < CW'(DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IW-1:0];
                        mem_wdata = i_value;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    // last element: seed the range stack with the whole buffer
                    if (i_last) begin
                        n_k = '0;
                        if (total >= CW'(2)) begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = {IW'(total - CW'(1)), IW'(0)};
                            n_sp      = CW'(1);
                            n_state   = S_POP;
                        end else begin
                            n_state = S_ORD;
                        end
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    stk_re    = 1'b1;
                    stk_raddr = IW'(r_sp - CW'(1));
                    n_sp      = r_sp - CW'(1);
                    n_state   = S_POPW;
                end
            end
            S_POPW: begin
                n_lo = stk_rdata[IW-1:0];
                n_hi = stk_rdata[SW-1:IW];
                if (stk_rdata[IW-1:0] >= stk_rdata[SW-1:IW]) begin
                    n_state = S_POP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = stk_rdata[SW-1:IW];
                    n_state   = S_PIV;
                end
            end
            S_PIV: begin
                n_pivot   = mem_rdata;
                n_b       = r_lo;
                n_j       = r_lo;
                mem_re    = 1'b1;
                mem_raddr = r_lo;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (le_pivot && (r_b != r_j)) begin
                    // fetch the boundary entry for a swap
                    n_aj      = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = r_b;
                    n_state   = S_SWP1;
                end else begin
                    if (le_pivot) begin
                        n_b = r_b + IW'(1);
                    end
                    n_j = j_next;
                    if (j_next < r_hi) begin
                        mem_re    = 1'b1;
                        mem_raddr = j_next;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SWP1: begin
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = r_aj;
                n_state   = S_SWP2;
            end
            S_SWP2: begin
                // old boundary entry still on the read port
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = mem_rdata;
                n_b       = r_b + IW'(1);
                n_j       = j_next;
                if (j_next < r_hi) begin
                    mem_re    = 1'b1;
                    mem_raddr = j_next;
                    n_state   = S_CMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                mem_re    = 1'b1;
                mem_raddr = r_b;
                n_state   = S_FIN1;
            end
            S_FIN1: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = mem_rdata;
                n_state   = S_FIN2;
            end
            S_FIN2: begin
                // pivot into place, push the low side
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = r_pivot;
                if (({1'b0, r_b} > {1'b0, r_lo} + (IW+1)'(1)) && (r_sp < CW'(DEPTH))) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sp[IW-1:0];
                    stk_wdata = {r_b - IW'(1), r_lo};
                    n_sp      = r_sp + CW'(1);
                end
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                // push the high side
                if (({1'b0, r_hi} > {1'b0, r_b} + (IW+1)'(1)) && (r_sp < CW'(DEPTH))) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sp[IW-1:0];
                    stk_wdata = {r_hi, r_b + IW'(1)};
                    n_sp      = r_sp + CW'(1);
                end
                n_state = S_POP;
            end
            S_ORD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
                n_state   = S_OWAIT;
            end
            S_OWAIT: begin
                n_out_valid = 1'b1;
                n_out_value = mem_rdata;
                n_out_final = ({1'b0, r_k} + CW'(1)) == r_count;
                n_state     = S_OHOLD;
            end
            S_OHOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_final) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_k       = r_k + IW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = r_k + IW'(1);
                        n_state   = S_OWAIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sp        <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_final <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_b         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_pivot     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
            r_out_final <= n_out_final;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_b         <= n_b;
            r_j         <= n_j;
            r_k         <= n_k;
            r_pivot     <= n_pivot;
        end
        r_aj        <= n_aj;
        r_out_value <= n_out_value;
    end

    // pending ranges are disjoint and hold two or more elements each
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(DEPTH / 2))
        else $error("range stack deeper than half the buffer");

    // the buffer never holds more than its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");

    // results come only from stored entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, r_k} < r_count))
        else $error("emitted index beyond element count");

    // a last transaction closes the input until the set is emitted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last) |=> !o_in_ready)
        else $error("input reopened right after last element");

    // boundary never passes the scan position during a partition
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SWP1 || r_state == S_SWP2) |-> (r_b <= r_j))
        else $error("partition boundary ahead of scan index");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;

    import qsort_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int VW    = DEFAULT_VALUE_WIDTH;

    localparam logic signed [VW-1:0] MAX_VAL = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN_VAL = {1'b1, {(VW-1){1'b0}}};

    // value patterns used to build a data set
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_DUPES,
        SHAPE_EXTREMES,
        SHAPE_ASCENDING,
        SHAPE_DESCENDING
    } t_set_shape;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 final_res;
        logic                 overflow;
    } t_sorted_entry;

    // keeps the data set being loaded and the sorted values still to come out
    class sort_checker;
        logic signed [VW-1:0] held[$];
        logic                 dropped;
        t_sorted_entry        awaited_sorted[$];
        int                   failures;
        int                   values_checked;
        int                   sets_sorted;
        int                   overflow_sets;

        function new();
            dropped        = 1'b0;
            failures       = 0;
            values_checked = 0;
            sets_sorted    = 0;
            overflow_sets  = 0;
        endfunction

        // one accepted input transaction
        function void note_element(logic signed [VW-1:0] v, logic is_last);
            logic signed [VW-1:0] key;
            int                   j;
            t_sorted_entry        e;
            if (held.size() < DEPTH) begin
                held.push_back(v);
            end else begin
                dropped = 1'b1;
            end
            if (!is_last) return;
            // ascending order, equal values keep their arrival order
            for (int i = 1; i < held.size(); i++) begin
                key = held[i];
                j   = i - 1;
                while (j >= 0 && held[j] > key) begin
                    held[j+1] = held[j];
                    j--;
                end
                held[j+1] = key;
            end
            for (int i = 0; i < held.size(); i++) begin
                e.value     = held[i];
                e.final_res = (i == held.size() - 1);
                e.overflow  = dropped;
                awaited_sorted.push_back(e);
            end
            sets_sorted++;
            if (dropped) overflow_sets++;
            held.delete();
            dropped = 1'b0;
        endfunction

        // one accepted output transaction
        function void check_sorted(logic signed [VW-1:0] v, logic f, logic o);
            t_sorted_entry e;
            if (awaited_sorted.size() == 0) begin
                $display("%0t: unexpected result value %0d final %0b overflow %0b",
                         $time, v, f, o);
                failures++;
                return;
            end
            e = awaited_sorted.pop_front();
            values_checked++;
            if (v !== e.value) begin
                $display("%0t: sorted_value expected %0d actual %0d", $time, e.value, v);
                failures++;
            end
            if (f !== e.final_res) begin
                $display("%0t: final_res expected %0b actual %0b", $time, e.final_res, f);
                failures++;
            end
            if (o !== e.overflow) begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, o);
                failures++;
            end
        endfunction

        function int pending();
            return awaited_sorted.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          o_in_ready;
    logic [VW-1:0] in_value;
    logic          in_last;
    logic          o_out_valid;
    logic          out_ready;
    logic [VW-1:0] o_sorted_value;
    logic          o_final_res;
    logic          o_overflow;

    int send_idle_pct;
    int recv_stall_pct;

    logic signed [VW-1:0] set_values[$];
    sort_checker          order_chk;

    quicksort_buffer_sorter #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (in_value),
        .i_last         (in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res),
        .o_overflow     (o_overflow)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver back-pressure
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            order_chk.check_sorted(o_sorted_value, o_final_res, o_overflow);
        end
    end

    // run limit
    initial begin
        #1500000;
        $display("quicksort_buffer_sorter: mismatch");
        $finish;
    end

    // one input transaction, with random gaps in front of it
    task automatic send_item(input logic [VW-1:0] v, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_value = v;
        in_last  = is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        order_chk.note_element(v, is_last);
        @(negedge i_clk);
    endtask

    // send set_values, last flag on the final one
    task automatic send_values();
        for (int i = 0; i < set_values.size(); i++) begin
            send_item(set_values[i], i == set_values.size() - 1);
        end
        in_valid = 1'b0;
    endtask

    task automatic send_set(input int count, input t_set_shape shape);
        logic signed [VW-1:0] run;
        logic signed [VW-1:0] v;
        run = $signed($urandom) >>> 4;
        set_values.delete();
        for (int i = 0; i < count; i++) begin
            case (shape)
                SHAPE_DUPES: begin
                    v = $signed(VW'($urandom_range(6))) - 3;
                end
                SHAPE_EXTREMES: begin
                    case ($urandom_range(4))
                        0: v = MIN_VAL;
                        1: v = MAX_VAL;
                        2: v = 0;
                        3: v = -1;
                        default: v = 1;
                    endcase
                end
                SHAPE_ASCENDING: begin
                    run = run + $urandom_range(3);
                    v   = run;
                end
                SHAPE_DESCENDING: begin
                    run = run - $urandom_range(3);
                    v   = run;
                end
                default: begin
                    v = $urandom;
                end
            endcase
            set_values.push_back(v);
        end
        send_values();
    endtask

    task automatic drain();
        while (order_chk.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    int phase_idle[4];
    int phase_stall[4];
    int phase_items;
    int count;

    initial begin
        order_chk      = new();
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_value       = '0;
        in_last        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        phase_idle     = '{0, 71, 0, 31};
        phase_stall    = '{0, 0, 71, 31};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed sets: single values, extremes, duplicates, sorted input
        set_values = '{MAX_VAL};
        send_values();
        set_values = '{MIN_VAL};
        send_values();
        set_values = '{MAX_VAL, MIN_VAL};
        send_values();
        set_values = '{0, -1, 1, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL, 0};
        send_values();
        set_values = '{5, 5, 5, 5};
        send_values();
        set_values = '{MIN_VAL, -1, 0, MAX_VAL};
        send_values();
        set_values = '{MAX_VAL, 1, -1, MIN_VAL};
        send_values();
        drain();

        // random sets under each idling pattern
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            phase_items    = 0;
            while (phase_items < 3) begin
                count = $urandom_range(1, 4);
                send_set(count, t_set_shape'($urandom_range(4)));
                phase_items += count;
            end
            // a full buffer whose last transaction is dropped
            if (p == 3) send_set(DEPTH + 1, SHAPE_RANDOM);
            drain();
        end

        repeat (50) @(posedge i_clk);

        $display("sorted %0d data sets, %0d values checked, %0d sets with dropped items",
                 order_chk.sets_sorted, order_chk.values_checked, order_chk.overflow_sets);
        $display("idling patterns: none, sender only, receiver only, both");
        if (order_chk.failures == 0 && order_chk.pending() == 0) begin
            $display("quicksort_buffer_sorter: match");
        end else begin
            $display("quicksort_buffer_sorter: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
